// File: sv/nrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrd_pkg: shared definitions for the numeric runaway run detector
// Widths, reset values of the control registers, codes, the per-detector
// event bundle and the byte classification functions.
// ----------------------------------------------------------------------------
package nrd_pkg;

   localparam int MAX_DIGITS_DEF = 6;

   localparam int RUN_W     = 7;
   localparam int GAP_W     = 6;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [RUN_W-1:0] RUN_LIMIT = 7'd127;
   localparam logic [GAP_W-1:0] GAP_LIMIT = 6'd63;

   localparam logic [RUN_W-1:0] COUNT_RUN_MIN_RST  = 7'd48;
   localparam logic [RUN_W-1:0] REPEAT_RUN_MIN_RST = 7'd64;
   localparam logic [GAP_W-1:0] MAX_GAP_RST        = 6'd12;

   localparam logic [7:0] ASCII_DOT = 8'h2E;

   typedef enum logic [1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_COUNT  = 2'd1,
      VERDICT_REPEAT = 2'd2
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNT_RUN_MIN  = 2'd0,
      CSR_REPEAT_RUN_MIN = 2'd1,
      CSR_MAX_GAP        = 2'd2
   } csr_index_type;

   // What one byte does to one detector, in this order: spoil, take, gap.
   typedef struct packed {
      logic take;
      logic spoil;
      logic gap;
      logic sep;
   } det_ev_type;

   function automatic logic is_digit(input logic [7:0] b);
      logic r;
      r = (b >= 8'h30) && (b <= 8'h39);
      return r;
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      logic r;
      r = is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
          || (b == 8'h5F) || (b == ASCII_DOT) || (b == 8'h2D);
      return r;
   endfunction

   function automatic logic is_sep(input logic [7:0] b);
      logic r;
      case (b) inside
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
         8'h2C, 8'h3B, 8'h3A, 8'h2F, 8'h7C, 8'h28, 8'h29,
         8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h2D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/nrd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrd_scan: numeric token scanner
// Accumulates digit runs, tracks the prefix and trailing-dot conditions and
// turns each byte into take / spoil / gap events for the two detectors.
// ----------------------------------------------------------------------------
module nrd_scan #(
   parameter int MAX_DIGITS = nrd_pkg::MAX_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic [7:0]                            byte_in,
   input  logic                                  last_in,
   output nrd_pkg::det_ev_type                   count_ev,
   output nrd_pkg::det_ev_type                   rep_ev,
   output logic [$clog2(10**MAX_DIGITS)-1:0]     token_value
);

   localparam int VAL_W = $clog2(10**MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   logic [VAL_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             long_ff, long_in;
   logic             prefix_ff, prefix_in;
   logic             dot_ff, dot_in;

   logic             b_digit, b_word, b_sep;
   logic             elig_end, elig_last;
   logic [VAL_W+3:0] value_x10;

   assign b_digit = nrd_pkg::is_digit(byte_in);
   assign b_word  = nrd_pkg::is_word(byte_in);
   assign b_sep   = nrd_pkg::is_sep(byte_in);

   // value * 10 + digit as shift-add
   assign value_x10 = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
                      + {{VAL_W{1'b0}}, byte_in[3:0]};

   assign elig_end = prefix_ff && !long_ff;

   always_comb begin
      value_in  = value_ff;
      cnt_in    = cnt_ff;
      long_in   = long_ff;
      prefix_in = prefix_ff;
      dot_in    = dot_ff;
      count_ev  = '0;
      rep_ev    = '0;
      elig_last = 1'b0;

      if (b_digit) begin
         rep_ev.spoil = dot_ff;
         dot_in       = 1'b0;
         if (cnt_ff == '0) begin
            value_in = VAL_W'(byte_in[3:0]);
            cnt_in   = CNT_W'(1);
            long_in  = 1'b0;
         end else if (cnt_ff < CNT_W'(MAX_DIGITS)) begin
            value_in = value_x10[VAL_W-1:0];
            cnt_in   = cnt_ff + CNT_W'(1);
         end else begin
            long_in = 1'b1;
         end
      end else begin
         if (cnt_ff != '0) begin
            // close the digit run: terminator, trailing dot or spoilt
            if (!b_word && elig_end && (cnt_ff >= CNT_W'(2))) begin
               count_ev.take = 1'b1;
            end else begin
               count_ev.spoil = 1'b1;
            end
            if (!b_word && elig_end) begin
               rep_ev.take = 1'b1;
            end else if ((byte_in == nrd_pkg::ASCII_DOT) && elig_end) begin
               dot_in = 1'b1;
            end else begin
               rep_ev.spoil = 1'b1;
            end
            cnt_in  = '0;
            long_in = 1'b0;
         end else if (dot_ff) begin
            rep_ev.take  = !b_word;
            rep_ev.spoil = b_word;
            dot_in       = 1'b0;
         end
         count_ev.gap = 1'b1;
         count_ev.sep = b_sep;
         rep_ev.gap   = !dot_in;
         rep_ev.sep   = b_sep;
         prefix_in    = !b_word;
      end

      if (last_in) begin
         // end of text closes whatever is still open
         elig_last = prefix_in && !long_in;
         if (cnt_in != '0) begin
            if (elig_last && (cnt_in >= CNT_W'(2))) begin
               count_ev.take = 1'b1;
            end
            if (elig_last) begin
               rep_ev.take = 1'b1;
            end
         end else if (dot_in) begin
            rep_ev.take = 1'b1;
         end
      end
   end

   assign token_value = value_in;

   always_ff @(posedge clock) begin
      if (reset || (adv && last_in)) begin
         value_ff  <= '0;
         cnt_ff    <= '0;
         long_ff   <= 1'b0;
         prefix_ff <= 1'b1;
         dot_ff    <= 1'b0;
      end else if (adv) begin
         value_ff  <= value_in;
         cnt_ff    <= cnt_in;
         long_ff   <= long_in;
         prefix_ff <= prefix_in;
         dot_ff    <= dot_in;
      end
   end

endmodule

// File: sv/nrd_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrd_track: run tracker for one detector
// Keeps the previous token, run length and gap state; SAME selects equal
// tokens (repeat) or previous-plus-one tokens (counting).
// ----------------------------------------------------------------------------
module nrd_track #(
   parameter int VAL_W = 20,
   parameter bit SAME  = 1'b0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       clear,
   input  nrd_pkg::det_ev_type        ev,
   input  logic [VAL_W-1:0]           token_value,
   input  logic [nrd_pkg::RUN_W-1:0]  run_min,
   input  logic [nrd_pkg::GAP_W-1:0]  max_gap,
   output logic                       fired
);

   logic [VAL_W-1:0]          prev_ff, prev_in;
   logic                      have_ff, have_in;
   logic [nrd_pkg::RUN_W-1:0] run_ff, run_in;
   logic [nrd_pkg::GAP_W-1:0] len_ff, len_in;
   logic                      clean_ff, clean_in;
   logic                      fired_ff, fired_in;

   logic                      clean_pre;
   logic                      related;

   assign clean_pre = clean_ff && !ev.spoil;
   assign related   = SAME ? (token_value == prev_ff)
                           : (token_value == (prev_ff + VAL_W'(1)));

   always_comb begin
      prev_in  = prev_ff;
      have_in  = have_ff;
      run_in   = run_ff;
      len_in   = len_ff;
      clean_in = clean_pre;
      fired_in = fired_ff;

      if (ev.take) begin
         if (have_ff) begin
            if (related && clean_pre && (len_ff <= max_gap)) begin
               if (run_ff < nrd_pkg::RUN_LIMIT) begin
                  run_in = run_ff + nrd_pkg::RUN_W'(1);
               end
            end else begin
               run_in = nrd_pkg::RUN_W'(1);
            end
            if (run_in >= run_min) begin
               fired_in = 1'b1;
            end
         end else begin
            run_in = nrd_pkg::RUN_W'(1);
         end
         prev_in  = token_value;
         have_in  = 1'b1;
         len_in   = '0;
         clean_in = 1'b1;
      end

      if (ev.gap) begin
         if (!ev.sep) begin
            clean_in = 1'b0;
         end
         // hold the length at its limit and mark the gap unclean
         if (len_in >= nrd_pkg::GAP_LIMIT) begin
            clean_in = 1'b0;
         end else begin
            len_in = len_in + nrd_pkg::GAP_W'(1);
         end
      end
   end

   assign fired = fired_in;

   always_ff @(posedge clock) begin
      if (reset || (adv && clear)) begin
         prev_ff  <= '0;
         have_ff  <= 1'b0;
         run_ff   <= '0;
         len_ff   <= '0;
         clean_ff <= 1'b1;
         fired_ff <= 1'b0;
      end else if (adv) begin
         prev_ff  <= prev_in;
         have_ff  <= have_in;
         run_ff   <= run_in;
         len_ff   <= len_in;
         clean_ff <= clean_in;
         fired_ff <= fired_in;
      end
   end

endmodule

// File: sv/numeric_runaway_run_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_runaway_run_detector: runaway counting / repeated number detector
// Scans a text one byte per beat and, on the last byte, reports whether a
// long run of incrementing or of equal numeric tokens was seen.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid / req_stall req_text_byte, req_last_byte
//  rsp      out        rsp_valid / rsp_stall rsp_verdict (one beat per text)
//  csr      in         csr_we                csr_index, csr_wdata
//
//  One byte per clock while req_stall is low. A byte is held in the input
//  register, the scanner and both trackers update from it while it is worked
//  on, and the verdict of a last byte lands in the result register on the next
//  edge. reset is synchronous; it clears the scan state and loads the register
//  defaults. req_stall rises only while a last byte waits behind an untaken
//  verdict.
// ----------------------------------------------------------------------------
module numeric_runaway_run_detector #(
   parameter int MAX_DIGITS = nrd_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_verdict,
   input  logic                          csr_we,
   input  logic [nrd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nrd_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int VAL_W = $clog2(10**MAX_DIGITS);

   logic [nrd_pkg::RUN_W-1:0] count_min_ff;
   logic [nrd_pkg::RUN_W-1:0] repeat_min_ff;
   logic [nrd_pkg::GAP_W-1:0] max_gap_ff;

   logic                      in_vld_ff;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;

   logic                      rsp_vld_ff, rsp_vld_in;
   nrd_pkg::verdict_type      verdict_ff, verdict_in;

   logic                      proc;
   nrd_pkg::det_ev_type       count_ev, rep_ev;
   logic [VAL_W-1:0]          token_value;
   logic                      count_fired, rep_fired;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_min_ff  <= nrd_pkg::COUNT_RUN_MIN_RST;
         repeat_min_ff <= nrd_pkg::REPEAT_RUN_MIN_RST;
         max_gap_ff    <= nrd_pkg::MAX_GAP_RST;
      end else if (csr_we) begin
         unique case (nrd_pkg::csr_index_type'(csr_index))
            nrd_pkg::CSR_COUNT_RUN_MIN:  count_min_ff  <= csr_wdata;
            nrd_pkg::CSR_REPEAT_RUN_MIN: repeat_min_ff <= csr_wdata;
            nrd_pkg::CSR_MAX_GAP:        max_gap_ff    <= csr_wdata[nrd_pkg::GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // a byte is worked on unless it is a last byte facing a held verdict
   assign proc      = in_vld_ff && (!in_last_ff || !rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_last_byte;
      end
   end

   nrd_scan #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .adv         (proc),
      .byte_in     (in_byte_ff),
      .last_in     (in_last_ff),
      .count_ev    (count_ev),
      .rep_ev      (rep_ev),
      .token_value (token_value)
   );

   nrd_track #(
      .VAL_W (VAL_W),
      .SAME  (1'b0)
   ) u_count (
      .clock       (clock),
      .reset       (reset),
      .adv         (proc),
      .clear       (in_last_ff),
      .ev          (count_ev),
      .token_value (token_value),
      .run_min     (count_min_ff),
      .max_gap     (max_gap_ff),
      .fired       (count_fired)
   );

   nrd_track #(
      .VAL_W (VAL_W),
      .SAME  (1'b1)
   ) u_repeat (
      .clock       (clock),
      .reset       (reset),
      .adv         (proc),
      .clear       (in_last_ff),
      .ev          (rep_ev),
      .token_value (token_value),
      .run_min     (repeat_min_ff),
      .max_gap     (max_gap_ff),
      .fired       (rep_fired)
   );

   // result register: counting wins over repeat
   always_comb begin
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      verdict_in = verdict_ff;
      if (proc && in_last_ff) begin
         rsp_vld_in = 1'b1;
         if (count_fired) begin
            verdict_in = nrd_pkg::VERDICT_COUNT;
         end else if (rep_fired) begin
            verdict_in = nrd_pkg::VERDICT_REPEAT;
         end else begin
            verdict_in = nrd_pkg::VERDICT_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_verdict = verdict_ff;

   // a processed last byte always leaves a verdict behind
   a_last_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      proc && in_last_ff |=> rsp_vld_ff)
      else $error("last byte processed without a verdict");

   // input stalls only behind a held verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && in_last_ff && rsp_vld_ff && rsp_stall)
      else $error("input stalled without a blocked verdict");

   // a shown verdict is one of the defined codes
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (verdict_ff == nrd_pkg::VERDICT_NONE)
                  || (verdict_ff == nrd_pkg::VERDICT_COUNT)
                  || (verdict_ff == nrd_pkg::VERDICT_REPEAT))
      else $error("undefined verdict code");

endmodule

// File: bench/numeric_runaway_run_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_runaway_run_detector_tb: self-checking bench for the run detector
// Streams texts built from numeric tokens and separators through the byte
// channel, predicts the verdict of every text and compares it with the
// result channel. Both sides idle at random, the receiver holds off once for
// a long stretch, and the control registers move between phases.
// ----------------------------------------------------------------------------
module numeric_runaway_run_detector_tb;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_BYTES     = 190;
   localparam logic [nrd_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {END_TERM, END_DOT, END_OTHER} run_end_type;

   typedef struct packed {
      bit [19:0] prev;
      bit        have;
      bit [6:0]  run;
      bit [5:0]  gap_len;
      bit        clean;
      bit        fired;
   } tracker_type;

   class verdict_scoreboard;
      bit [6:0]             count_min;
      bit [6:0]             repeat_min;
      bit [5:0]             gap_max;
      bit [19:0]            num_value;
      int unsigned          num_digits;
      bit                   num_too_long;
      bit                   prefix_ok;
      bit                   dot_wait;
      tracker_type          count_trk;
      tracker_type          rep_trk;
      nrd_pkg::verdict_type verdicts_due[$];
      int                   errors;

      function new();
         count_min  = nrd_pkg::COUNT_RUN_MIN_RST;
         repeat_min = nrd_pkg::REPEAT_RUN_MIN_RST;
         gap_max    = nrd_pkg::MAX_GAP_RST;
         errors     = 0;
         clear_text();
      endfunction

      function void clear_text();
         tracker_type fresh;
         fresh        = '0;
         fresh.clean  = 1'b1;
         count_trk    = fresh;
         rep_trk      = fresh;
         num_value    = '0;
         num_digits   = 0;
         num_too_long = 1'b0;
         prefix_ok    = 1'b1;
         dot_wait     = 1'b0;
      endfunction

      function void write_reg(logic [nrd_pkg::CSR_IDX_W-1:0] idx,
                              logic [nrd_pkg::CSR_W-1:0] value);
         case (idx)
            nrd_pkg::CSR_COUNT_RUN_MIN:  count_min  = value[6:0];
            nrd_pkg::CSR_REPEAT_RUN_MIN: repeat_min = value[6:0];
            nrd_pkg::CSR_MAX_GAP:        gap_max    = value[5:0];
            default: ;
         endcase
      endfunction

      function bit digit_byte(bit [7:0] b);
         return (b >= 8'h30) && (b <= 8'h39);
      endfunction

      function bit word_byte(bit [7:0] b);
         return digit_byte(b) || ((b >= 8'h41) && (b <= 8'h5A)) ||
                ((b >= 8'h61) && (b <= 8'h7A)) || (b == 8'h5F) || (b == 8'h2E) || (b == 8'h2D);
      endfunction

      function bit sep_byte(bit [7:0] b);
         case (b)
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h2C, 8'h3B, 8'h3A, 8'h2F,
            8'h7C, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h2D: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function tracker_type take(tracker_type t, bit [19:0] v, bit same, bit [6:0] min_run);
         bit related;
         if (t.have) begin
            related = same ? (v == t.prev) : ({1'b0, v} == {1'b0, t.prev} + 21'd1);
            if (related && t.clean && (t.gap_len <= gap_max)) begin
               if (t.run < nrd_pkg::RUN_LIMIT) t.run = t.run + 7'd1;
            end else begin
               t.run = 7'd1;
            end
            if (t.run >= min_run) t.fired = 1'b1;
         end else begin
            t.run = 7'd1;
         end
         t.prev    = v;
         t.have    = 1'b1;
         t.gap_len = '0;
         t.clean   = 1'b1;
         return t;
      endfunction

      // the gap length sticks at its ceiling; anything longer spoils the gap
      function tracker_type widen_gap(tracker_type t, bit sep);
         if (!sep) t.clean = 1'b0;
         if (t.gap_len >= nrd_pkg::GAP_LIMIT) t.clean = 1'b0;
         else t.gap_len = t.gap_len + 6'd1;
         return t;
      endfunction

      function void close_digits(run_end_type how);
         bit ok;
         ok = prefix_ok && !num_too_long;
         if ((how == END_TERM) && ok && (num_digits >= 2))
            count_trk = take(count_trk, num_value, 1'b0, count_min);
         else
            count_trk.clean = 1'b0;
         if ((how == END_TERM) && ok)
            rep_trk = take(rep_trk, num_value, 1'b1, repeat_min);
         else if ((how == END_DOT) && ok)
            dot_wait = 1'b1;
         else
            rep_trk.clean = 1'b0;
         num_digits   = 0;
         num_too_long = 1'b0;
      endfunction

      function void settle_dot(bit terminated);
         if (terminated) rep_trk = take(rep_trk, num_value, 1'b1, repeat_min);
         else rep_trk.clean = 1'b0;
         dot_wait = 1'b0;
      endfunction

      function void note_byte(bit [7:0] b, bit last);
         bit                   word;
         bit                   sep;
         nrd_pkg::verdict_type due;
         word = word_byte(b);
         sep  = sep_byte(b);
         if (digit_byte(b)) begin
            if (dot_wait) settle_dot(1'b0);
            if (num_digits == 0) begin
               num_value    = 20'(b - 8'h30);
               num_digits   = 1;
               num_too_long = 1'b0;
            end else if (num_digits < nrd_pkg::MAX_DIGITS_DEF) begin
               num_value  = 20'(num_value * 20'd10 + 20'(b - 8'h30));
               num_digits = num_digits + 1;
            end else begin
               num_too_long = 1'b1;
            end
         end else begin
            if (num_digits > 0)
               close_digits(!word ? END_TERM
                                  : ((b == nrd_pkg::ASCII_DOT) ? END_DOT : END_OTHER));
            else if (dot_wait)
               settle_dot(!word);
            count_trk = widen_gap(count_trk, sep);
            if (!dot_wait) rep_trk = widen_gap(rep_trk, sep);
            prefix_ok = !word;
         end
         if (last) begin
            if (num_digits > 0) close_digits(END_TERM);
            else if (dot_wait) settle_dot(1'b1);
            if (count_trk.fired) due = nrd_pkg::VERDICT_COUNT;
            else if (rep_trk.fired) due = nrd_pkg::VERDICT_REPEAT;
            else due = nrd_pkg::VERDICT_NONE;
            verdicts_due = {verdicts_due, due};
            clear_text();
         end
      endfunction

      function void check_verdict(logic [1:0] got);
         nrd_pkg::verdict_type want;
         if (verdicts_due.size() == 0) begin
            $error("verdict: expected none, actual %0d", got);
            errors++;
         end else begin
            want = verdicts_due.pop_front();
            if (got !== want) begin
               $error("verdict: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_text_byte = '0;
   logic                          req_last_byte = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_verdict;
   logic                          csr_we = 1'b0;
   logic [nrd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [nrd_pkg::CSR_W-1:0]     csr_wdata = '0;

   verdict_scoreboard sb;
   bit [7:0] text_buf[$];
   string    sep_set   = " \t\n\013\014\r,;:/|()[]{}<>-";
   string    spoil_set = "#a._!";
   int       bytes_sent    = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       hold_requests = 0;
   int       hold_taken    = 0;
   int       hold_left     = 0;
   int       cycle_count   = 0;

   numeric_runaway_run_detector dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: a requested hold-off wins over the random stalls
   always @(negedge clock) begin
      if (hold_requests != hold_taken) begin
         hold_taken <= hold_requests;
         hold_left  <= HOLD_OFF_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** numeric_runaway_run_detector: FAILED **");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_verdict(rsp_verdict);
      end
   end

   function automatic int unsigned pow10(int n);
      int unsigned p;
      p = 1;
      repeat (n) p = p * 10;
      return p;
   endfunction

   // enter and leave on a falling edge; valid stays up for a following beat
   task automatic send_byte(bit [7:0] b, bit last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic flush_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_byte(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic add_byte(bit [7:0] b);
      text_buf = {text_buf, b};
   endtask

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic push_num(int unsigned v, bit pad);
      if (pad) push_str("0");
      push_str($sformatf("%0d", v));
   endtask

   task automatic push_gap(int len, bit spoil);
      int base;
      base = text_buf.size();
      repeat (len) add_byte(sep_set[$urandom_range(0, sep_set.len() - 1)]);
      if (spoil)
         text_buf[base + $urandom_range(0, len - 1)] =
            spoil_set[$urandom_range(0, spoil_set.len() - 1)];
   endtask

   task automatic push_run(int unsigned first, int n, int unsigned step, string sep);
      for (int i = 0; i < n; i++) begin
         push_num(first + i * step, 1'b0);
         if (i < n - 1) push_str(sep);
      end
      flush_text();
   endtask

   // shapes: counting runs, repeat runs (some with dots), mixed tokens, noise
   task automatic gen_text();
      int          shape;
      int          tokens;
      int          width;
      int          gap_len;
      int          pick;
      int unsigned value;
      int unsigned low;
      int unsigned high;
      bit          dotted;
      shape = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) push_gap($urandom_range(1, 3), 1'($urandom_range(0, 1)));
      if (shape == 9) begin
         repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         tokens = $urandom_range(1, 9);
         width  = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(1, 6);
         low    = (width == 1) ? 0 : pow10(width - 1);
         high   = pow10(width) - 1;
         value  = ($urandom_range(0, 3) == 0) ? high - $urandom_range(0, 3)
                                              : $urandom_range(low, high);
         dotted = (shape >= 5) && (shape < 8) && ($urandom_range(0, 2) == 0);
         for (int i = 0; i < tokens; i++) begin
            if (i > 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 7) gap_len = $urandom_range(1, 3);
               else if (pick < 9) gap_len = int'(sb.gap_max) - 1 + int'($urandom_range(0, 2));
               else gap_len = $urandom_range(20, 70);
               if (gap_len < 1) gap_len = 1;
               push_gap(gap_len, $urandom_range(0, 11) == 0);
               if (shape < 5)
                  value = value + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 1);
               else if (shape < 8)
                  value = value + ($urandom_range(0, 9) == 0);
               else
                  value = $urandom_range(0, 999999);
            end
            push_num(value, $urandom_range(0, 9) == 0);
            if (dotted) push_str(".");
         end
      end
      case ($urandom_range(0, 4))
         1: push_gap(1, 1'b0);
         2: push_str(".");
         3: push_str("x");
         4: add_byte(8'($urandom_range(0, 255)));
         default: ;
      endcase
      flush_text();
   endtask

   task automatic random_phase(int target);
      bytes_sent = 0;
      while (bytes_sent < target) gen_text();
   endtask

   task automatic set_regs(logic [nrd_pkg::CSR_W-1:0] c_min, logic [nrd_pkg::CSR_W-1:0] r_min,
                           logic [nrd_pkg::CSR_W-1:0] g_max, bit touch_spare);
      logic [nrd_pkg::CSR_W-1:0] junk;
      junk = nrd_pkg::CSR_W'($urandom_range(0, 127));
      csr_we    <= 1'b1;
      csr_index <= nrd_pkg::CSR_COUNT_RUN_MIN;
      csr_wdata <= c_min;
      sb.write_reg(nrd_pkg::CSR_COUNT_RUN_MIN, c_min);
      @(negedge clock);
      csr_index <= nrd_pkg::CSR_REPEAT_RUN_MIN;
      csr_wdata <= r_min;
      sb.write_reg(nrd_pkg::CSR_REPEAT_RUN_MIN, r_min);
      @(negedge clock);
      csr_index <= nrd_pkg::CSR_MAX_GAP;
      csr_wdata <= g_max;
      sb.write_reg(nrd_pkg::CSR_MAX_GAP, g_max);
      @(negedge clock);
      if (touch_spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= junk;
         sb.write_reg(CSR_SPARE, junk);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, wait for every verdict, then let the pipeline drain
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.verdicts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      sb = new();
      send_idle_pct = 6;
      recv_idle_pct = 68;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_regs(7'd2, 7'd2, 7'd1, 1'b0);
      push_str("9");                flush_text();
      push_str("12 13");            flush_text();
      push_str("5.,5.");            flush_text();
      push_str("1234567 1234567");  flush_text();
      push_str("a12 13");           flush_text();
      push_str("7  7");             flush_text();
      push_str("4.x 4");            flush_text();
      push_str("99-100");           flush_text();
      push_str("999999 1000000");   flush_text();
      push_str("3_3");              flush_text();
      add_byte(8'h00);              flush_text();
      add_byte(8'hFF);              flush_text();
      quiesce();

      set_regs(7'd3, 7'd4, 7'd12, 1'b1);
      random_phase(PHASE_BYTES);
      quiesce();

      // below-two minimums fire on the second token; the gap write is masked
      send_idle_pct = 68;
      recv_idle_pct = 6;
      set_regs(7'd0, 7'd1, 7'h7F, 1'b0);
      random_phase(PHASE_BYTES);
      quiesce();

      // longest runs: exact threshold, then saturation
      set_regs(7'd127, 7'd127, 7'd63, 1'b0);
      push_run(10, 136, 1, " ");
      push_run(7, 130, 0, ". ");
      quiesce();

      // runs one token short of the threshold
      set_regs(7'd20, 7'd20, 7'd63, 1'b0);
      push_run(11, 19, 1, " ");
      push_run(50, 19, 0, ";");
      quiesce();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_regs(7'd5, 7'd2, 7'd0, 1'b0);
      hold_requests <= hold_requests + 1;
      repeat (40) begin
         push_str("1 2");
         flush_text();
      end
      quiesce();
      set_regs(7'd4, 7'd3, 7'd5, 1'b1);
      random_phase(PHASE_BYTES);
      quiesce();

      if ((sb.errors == 0) && (sb.verdicts_due.size() == 0))
         $display("** numeric_runaway_run_detector: PASSED **");
      else
         $display("** numeric_runaway_run_detector: FAILED **");
      $finish;
   end

endmodule
